### rtl/core/thrust_curve_inverse_unit_defines.svh
// -----------------------------------------------------------------------------
// Thrust curve inverse assertion macros
// Shared concurrent assertion forms for the checker of the unit.
// -----------------------------------------------------------------------------
`ifndef THRUST_CURVE_INVERSE_UNIT_DEFINES_SVH
`define THRUST_CURVE_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TCI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thrust curve inverse check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define TCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thrust curve inverse check failed");

`endif

### rtl/core/tci_pkg.sv
// -----------------------------------------------------------------------------
// Thrust curve inverse package
// Widths, register indexes and the tag types carried along the cell chains.
// -----------------------------------------------------------------------------
`default_nettype none

package tci_pkg;

    localparam int RAD_W  = 128;
    localparam int ROOT_W = 64;
    localparam int REM_W  = 67;
    localparam int NUM_W  = 64;
    localparam int DIV_W  = 32;
    localparam int BM_W   = 63;

    localparam logic [14:0] DEAD_BAND_SCALE = 15'd10000;
    localparam logic [63:0] Q_LIMIT         = 64'd1 << 40;

    typedef enum logic [2:0] {
        REG_GAIN_COEFF    = 3'd0,
        REG_SPEED_COEFF   = 3'd1,
        REG_FORWARD_LIMIT = 3'd2,
        REG_REVERSE_LIMIT = 3'd3,
        REG_MIDDLE_SIGNAL = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic            db;
        logic            rev;
        logic            bneg;
        logic [BM_W-1:0] bm;
    } sq_tag_t;

    typedef struct packed {
        logic db;
        logic nneg;
    } dv_tag_t;

endpackage

`default_nettype wire

### rtl/core/tci_sqrt_cell.sv
// -----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root; passes its result on each cycle that en is high.
// -----------------------------------------------------------------------------
`default_nettype none

module tci_sqrt_cell
    import tci_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire logic [RAD_W-1:0]  rad_in,
    input  wire logic [REM_W-1:0]  rem_in,
    input  wire logic [ROOT_W-1:0] root_in,
    input  wire sq_tag_t           tag_in,
    output logic                   valid_out,
    output logic [RAD_W-1:0]       rad_out,
    output logic [REM_W-1:0]       rem_out,
    output logic [ROOT_W-1:0]      root_out,
    output sq_tag_t                tag_out
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
            rem_out  <= take ? (rem_sh - trial) : rem_sh;
            root_out <= {root_in[ROOT_W-2:0], take};
            tag_out  <= tag_in;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tci_div_cell.sv
// -----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division; quotient bits shift into the dividend.
// -----------------------------------------------------------------------------
`default_nettype none

module tci_div_cell
    import tci_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [DIV_W-1:0] divisor,
    input  wire logic             valid_in,
    input  wire logic [NUM_W-1:0] num_in,
    input  wire logic [DIV_W-1:0] rem_in,
    input  wire dv_tag_t          tag_in,
    output logic                  valid_out,
    output logic [NUM_W-1:0]      num_out,
    output logic [DIV_W-1:0]      rem_out,
    output dv_tag_t               tag_out
);

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] diff;
    logic           take;

    assign rem_sh = {rem_in, num_in[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, divisor});
    assign diff   = rem_sh - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out <= {num_in[NUM_W-2:0], take};
            rem_out <= take ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            tag_out <= tag_in;
        end
    end

endmodule

`default_nettype wire

### rtl/core/thrust_curve_inverse_unit.sv
// -----------------------------------------------------------------------------
// Thrust curve inverse unit
// Turns a thrust demand and axial water speed into a thruster drive signal.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                               Handshake
//   s_axis    in         thrust_demand, axial_speed            s_tvalid / s_tready
//   m_axis    out        drive_signal                          m_tvalid / m_tready
//   cfg       in         cfg_index, cfg_data                   cfg_valid / cfg_ready
//
// One demand is accepted every cycle while s_tready is high. Each one passes
// through 135 register stages: five front stages, 64 square root cells, one
// combining stage, 64 divider cells and the output register. Most of these
// stages are the one-bit cells of the square root and divider chains.
// Reset is asynchronous and active low; it clears valid flags and loads the
// register defaults. A stalled output first fills a one-entry skid buffer; only
// then does the whole pipeline hold and s_tready drop.
// -----------------------------------------------------------------------------
`default_nettype none

module thrust_curve_inverse_unit
    import tci_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] thrust_demand, [63:32] axial_speed
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] drive_signal
    // Register writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int SH = 2 * FRAC_BITS + 2;

    // Configuration registers. The user must change them only while no transaction
    // is in flight; the block does not enforce this. Every stage reads them directly.
    logic [30:0]        gain_reg;
    logic [30:0]        speed_reg;
    logic [30:0]        fwd_reg;
    logic signed [31:0] revl_reg;
    logic signed [31:0] mid_reg;
    logic [30:0]        g_eff;

    assign cfg_ready = 1'b1;
    assign g_eff     = (gain_reg == 31'd0) ? 31'd1 : gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 31'd65536;
            speed_reg <= 31'd0;
            fwd_reg   <= 31'd655360;
            revl_reg  <= -32'sd655360;
            mid_reg   <= 32'sd98304000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_COEFF:    gain_reg  <= cfg_data[30:0];
                REG_SPEED_COEFF:   speed_reg <= cfg_data[30:0];
                REG_FORWARD_LIMIT: fwd_reg   <= cfg_data[30:0];
                REG_REVERSE_LIMIT: revl_reg  <= $signed(cfg_data);
                REG_MIDDLE_SIGNAL: mid_reg   <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid buffer is full.
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Stage A: clamp and classify the demand against the dead band.
    logic signed [31:0] thr_in;
    logic signed [31:0] thr_cl;
    logic signed [46:0] thr_scaled;
    logic               a_valid_reg;
    logic signed [31:0] a_thr_reg;
    logic signed [31:0] a_v_reg;
    logic               a_fwd_reg;
    logic               a_rev_reg;

    always_comb
    begin
        thr_in = $signed(s_tdata[31:0]);
        thr_cl = thr_in;
        if (thr_cl < revl_reg)
        begin
            thr_cl = revl_reg;
        end
        if (thr_cl > $signed({1'b0, fwd_reg}))
        begin
            thr_cl = $signed({1'b0, fwd_reg});
        end
        thr_scaled = 47'(thr_cl) * $signed({32'd0, DEAD_BAND_SCALE});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_thr_reg <= thr_cl;
            a_v_reg   <= $signed(s_tdata[63:32]);
            a_fwd_reg <= thr_scaled > $signed({16'd0, fwd_reg});
            a_rev_reg <= !(thr_scaled > $signed({16'd0, fwd_reg}))
                         && (thr_scaled < 47'(revl_reg));
        end
    end

    // Stage B: speed term b = t2*|v| and thrust term t1*|thr|.
    logic [31:0]     v_mag;
    logic [31:0]     t_mag;
    logic            b_valid_reg;
    logic [BM_W-1:0] b_bm_reg;
    logic [BM_W-1:0] b_pm_reg;
    logic            b_bneg_reg;
    logic            b_tneg_reg;
    logic            b_rev_reg;
    logic            b_db_reg;

    assign v_mag = a_v_reg[31] ? (32'd0 - a_v_reg) : a_v_reg;
    assign t_mag = a_thr_reg[31] ? (32'd0 - a_thr_reg) : a_thr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_bm_reg   <= BM_W'(speed_reg * v_mag);
            b_pm_reg   <= BM_W'(g_eff * t_mag);
            b_bneg_reg <= a_v_reg[31];
            b_tneg_reg <= a_thr_reg[31] != a_rev_reg;
            b_rev_reg  <= a_rev_reg;
            b_db_reg   <= !a_fwd_reg && !a_rev_reg;
        end
    end

    // Stage C: partial products of b*b and the shifted thrust term.
    logic [31:0]      bm_lo;
    logic [30:0]      bm_hi;
    logic             c_valid_reg;
    logic [63:0]      c_ll_reg;
    logic [62:0]      c_lh_reg;
    logic [61:0]      c_hh_reg;
    logic [RAD_W-1:0] c_term_reg;
    sq_tag_t          c_tag_reg;
    logic             c_tneg_reg;

    assign bm_lo = b_bm_reg[31:0];
    assign bm_hi = b_bm_reg[62:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ll_reg   <= bm_lo * bm_lo;
            c_lh_reg   <= bm_lo * bm_hi;
            c_hh_reg   <= bm_hi * bm_hi;
            c_term_reg <= {65'd0, b_pm_reg} << SH;
            c_tag_reg  <= '{db: b_db_reg, rev: b_rev_reg, bneg: b_bneg_reg, bm: b_bm_reg};
            c_tneg_reg <= b_tneg_reg;
        end
    end

    // Stage D: b*b summed to 128 bits.
    logic             d_valid_reg;
    logic [RAD_W-1:0] d_sq_reg;
    logic [RAD_W-1:0] d_term_reg;
    sq_tag_t          d_tag_reg;
    logic             d_tneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_sq_reg   <= {2'd0, c_hh_reg, 64'd0} + {32'd0, c_lh_reg, 33'd0}
                          + {64'd0, c_ll_reg};
            d_term_reg <= c_term_reg;
            d_tag_reg  <= c_tag_reg;
            d_tneg_reg <= c_tneg_reg;
        end
    end

    // Stage E: discriminant, floored at zero when the thrust term is subtracted.
    logic             e_valid_reg;
    logic [RAD_W-1:0] e_delta_reg;
    sq_tag_t          e_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!d_tneg_reg)
            begin
                e_delta_reg <= d_sq_reg + d_term_reg;
            end
            else if (d_term_reg <= d_sq_reg)
            begin
                e_delta_reg <= d_sq_reg - d_term_reg;
            end
            else
            begin
                e_delta_reg <= '0;
            end
            e_tag_reg <= d_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Square root chain: one root bit per cell.
    logic              sq_valid [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rad   [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root  [ROOT_W+1];
    sq_tag_t           sq_tag   [ROOT_W+1];

    assign sq_valid[0] = e_valid_reg;
    assign sq_rad[0]   = e_delta_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_tag[0]   = e_tag_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        tci_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .tag_in    (sq_tag[i]),
            .valid_out (sq_valid[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .tag_out   (sq_tag[i+1])
        );
    end

    // Combining stage: numerator b +/- root as sign and magnitude.
    logic [ROOT_W-1:0] s_root;
    logic [ROOT_W-1:0] s_bm;
    sq_tag_t           s_tag;
    logic              n_valid_reg;
    logic [NUM_W-1:0]  n_num_reg;
    dv_tag_t           n_tag_reg;

    assign s_root = sq_root[ROOT_W];
    assign s_tag  = sq_tag[ROOT_W];
    assign s_bm   = {1'b0, s_tag.bm};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_tag_reg.db <= s_tag.db;
            if (s_tag.rev == s_tag.bneg)
            begin
                n_num_reg      <= s_root + s_bm;
                n_tag_reg.nneg <= s_tag.bneg;
            end
            else if (s_root >= s_bm)
            begin
                n_num_reg      <= s_root - s_bm;
                n_tag_reg.nneg <= s_tag.rev;
            end
            else
            begin
                n_num_reg      <= s_bm - s_root;
                n_tag_reg.nneg <= s_tag.bneg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n_valid_reg <= sq_valid[ROOT_W];
        end
    end

    // Divider chain: numerator over 2*t1, one quotient bit per cell.
    logic [DIV_W-1:0] divisor;
    logic             dv_valid [NUM_W+1];
    logic [NUM_W-1:0] dv_num   [NUM_W+1];
    logic [DIV_W-1:0] dv_rem   [NUM_W+1];
    dv_tag_t          dv_tag   [NUM_W+1];

    assign divisor     = {g_eff, 1'b0};
    assign dv_valid[0] = n_valid_reg;
    assign dv_num[0]   = n_num_reg;
    assign dv_rem[0]   = '0;
    assign dv_tag[0]   = n_tag_reg;

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        tci_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (divisor),
            .valid_in  (dv_valid[j]),
            .num_in    (dv_num[j]),
            .rem_in    (dv_rem[j]),
            .tag_in    (dv_tag[j]),
            .valid_out (dv_valid[j+1]),
            .num_out   (dv_num[j+1]),
            .rem_out   (dv_rem[j+1]),
            .tag_out   (dv_tag[j+1])
        );
    end

    // Final result: limit the quotient, apply sign, add the middle signal and
    // saturate to 32 bits. Inside the dead band the middle signal is passed.
    logic [NUM_W-1:0]   q_full;
    logic [40:0]        q_lim;
    logic signed [42:0] q_signed;
    logic signed [42:0] res_wide;
    logic [31:0]        res;
    logic               res_valid;
    dv_tag_t            f_tag;

    assign q_full    = dv_num[NUM_W];
    assign f_tag     = dv_tag[NUM_W];
    assign res_valid = dv_valid[NUM_W];

    always_comb
    begin
        q_lim    = (q_full > Q_LIMIT) ? Q_LIMIT[40:0] : q_full[40:0];
        q_signed = f_tag.nneg ? -$signed({2'b00, q_lim}) : $signed({2'b00, q_lim});
        res_wide = q_signed + 43'(mid_reg);
        if (f_tag.db)
        begin
            res = mid_reg;
        end
        else if (res_wide > 43'sd2147483647)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (res_wide < -43'sd2147483648)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = res_wide[31:0];
        end
    end

    // Output register with a one-entry skid buffer behind it.
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_tready)
        begin
            if (res_valid && en)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_tready)
        begin
            if (res_valid && en)
            begin
                skid_data_reg <= res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### rtl/core/tci_checker.sv
// -----------------------------------------------------------------------------
// Thrust curve inverse checker
// Port-level assertions on the unit, attached by a bind statement.
// -----------------------------------------------------------------------------
`default_nettype none

`include "thrust_curve_inverse_unit_defines.svh"

module tci_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [31:0] cfg_data
);

    // A held result stays offered.
    `TCI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A held result keeps its value.
    `TCI_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // The input side only backs up once a result is waiting at the output.
    `TCI_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid)

    // Register writes are never refused.
    `TCI_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind thrust_curve_inverse_unit tci_checker u_tci_checker (.*);

`default_nettype wire

### bench/thrust_curve_inverse_unit_tb.sv
// ----------------------------------------------------------------------------
// Thrust curve inverse unit testbench
// Drives thrust demands and axial speeds through the unit under several
// register settings and checks every drive signal against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module thrust_curve_inverse_unit_tb;
    import tci_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 134;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] thrust_demand, [63:32] axial_speed
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] drive_signal
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    thrust_curve_inverse_unit #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the unit's registers.
    logic [63:0] gain_mag;
    logic [63:0] speed_mag;
    logic signed [63:0] fwd_lim;
    logic signed [63:0] rev_lim;
    logic signed [63:0] mid_sig;

    logic [31:0] expected_drive[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Integer square root of a 128 bit value, bit by bit.
    function automatic logic [63:0] root_floor(input logic [127:0] d);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= d)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] drive_for(input logic [31:0] demand,
                                              input logic [31:0] speed);
        logic signed [63:0] thr;
        logic signed [63:0] v;
        logic [63:0] g;
        logic fwd;
        logic rev;
        logic [63:0] bm;
        logic [63:0] pm;
        logic [127:0] delta;
        logic [127:0] term;
        logic [63:0] s;
        logic [63:0] nm;
        logic [63:0] q;
        logic nneg;
        logic signed [63:0] res;
        thr = {{32{demand[31]}}, demand};
        v = {{32{speed[31]}}, speed};
        g = (gain_mag == 0) ? 64'd1 : gain_mag;
        if (thr < rev_lim)
            thr = rev_lim;
        if (thr > fwd_lim)
            thr = fwd_lim;
        fwd = thr * 10000 > fwd_lim;
        rev = !fwd && (thr * 10000 < rev_lim);
        if (!fwd && !rev)
            return mid_sig[31:0];
        bm = speed_mag * ((v < 0) ? -v : v);
        delta = 128'(bm) * 128'(bm);
        pm = g * ((thr < 0) ? -thr : thr);
        term = 128'(pm) << (2 * FRAC + 2);
        if ((thr < 0) == rev)
            delta = delta + term;
        else if (term <= delta)
            delta = delta - term;
        else
            delta = '0;
        s = root_floor(delta);
        if (rev == (v < 0))
        begin
            nm = s + bm;
            nneg = v < 0;
        end
        else if (s >= bm)
        begin
            nm = s - bm;
            nneg = rev;
        end
        else
        begin
            nm = bm - s;
            nneg = v < 0;
        end
        q = nm / (2 * g);
        if (q > Q_LIMIT)
            q = Q_LIMIT;
        res = (nneg ? -$signed(q) : $signed(q)) + mid_sig;
        if (res > 64'sh7FFFFFFF)
            res = 64'sh7FFFFFFF;
        if (res < -64'sh80000000)
            res = -64'sh80000000;
        return res[31:0];
    endfunction

    // Registers are only written once every transaction has left the unit.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_COEFF:    gain_mag = {33'd0, value[30:0]};
            REG_SPEED_COEFF:   speed_mag = {33'd0, value[30:0]};
            REG_FORWARD_LIMIT: fwd_lim = {33'd0, value[30:0]};
            REG_REVERSE_LIMIT: rev_lim = {{32{value[31]}}, value};
            REG_MIDDLE_SIGNAL: mid_sig = {{32{value[31]}}, value};
            default: ;
        endcase
    endtask

    // Waits for the unit to drain; the extra wait covers the pipeline.
    task automatic drain();
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Sends one transaction, with a random idle gap first, and queues the
    // predictor's drive signal as the expected result.
    task automatic send_item(input logic [31:0] demand, input logic [31:0] speed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {speed, demand};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_drive.push_back(drive_for(demand, speed));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(2000) - 1000;
            3: return ($urandom_range(1) ? 32'd1 : -32'd1) * $urandom_range(1 << 22);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drive.size() == 0)
            begin
                $display("%0t drive_signal unexpected: expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata !== expected_drive[0])
                begin
                    $display("%0t drive_signal mismatch: expected %h, actual %h",
                             $time, expected_drive[0], m_tdata);
                    errors++;
                end
                void'(expected_drive.pop_front());
            end
        end
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Directed table: demand, speed, and a known drive signal where it is obvious.
    typedef struct {
        logic [31:0] demand;
        logic [31:0] speed;
        bit          known;
        logic [31:0] drive;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{32'd0, 32'd0, 1, 32'd98304000},            // zero thrust gives the middle
        '{32'd65, 32'd0, 1, 32'd98304000},           // just inside the dead band
        '{-32'd65, 32'd0, 1, 32'd98304000},
        '{32'd66, 32'd0, 0, 32'd0},                  // just outside forward
        '{-32'd66, 32'd0, 0, 32'd0},
        '{32'h7FFFFFFF, 32'd0, 0, 32'd0},            // clamped to forward limit
        '{32'h80000000, 32'd0, 0, 32'd0},            // clamped to reverse limit
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'd0},
        '{32'h80000000, 32'h80000000, 0, 32'd0},
        '{32'd65536, 32'hFFFF0000, 0, 32'd0},
        '{-32'd65536, 32'd65536, 0, 32'd0}
    };

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GAIN_COEFF;
        cfg_data = '0;
        hold_off = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 16;
        recv_idle_pct = 65;
        gain_mag = 64'd65536;
        speed_mag = 64'd0;
        fwd_lim = 64'sd655360;
        rev_lim = -64'sd655360;
        mid_sig = 64'sd98304000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings.
        foreach (directed[i])
        begin
            if (directed[i].known &&
                drive_for(directed[i].demand, directed[i].speed) !== directed[i].drive)
            begin
                $display("%0t table row %0d: expected %h, actual %h", $time, i,
                         directed[i].drive,
                         drive_for(directed[i].demand, directed[i].speed));
                errors++;
            end
            send_item(directed[i].demand, directed[i].speed);
        end
        s_tvalid <= 1'b0;
        drain();

        // Extreme settings: zero gain, big speed coefficient, full limits
        // and a saturating middle signal.
        write_reg(REG_GAIN_COEFF, 32'd0);
        write_reg(REG_SPEED_COEFF, 32'h7FFFFFFF);
        write_reg(REG_FORWARD_LIMIT, 32'h7FFFFFFF);
        write_reg(REG_REVERSE_LIMIT, 32'h80000000);
        write_reg(REG_MIDDLE_SIGNAL, 32'h7FFFFFFF);
        send_item(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(32'h80000000, 32'h7FFFFFFF);
        send_item(32'h80000000, 32'h80000000);
        write_reg(REG_MIDDLE_SIGNAL, 32'h80000000);
        send_item(32'h80000000, 32'd1);
        send_item(32'h7FFFFFFF, 32'h80000000);
        s_tvalid <= 1'b0;
        drain();
        // Crossed limits: reverse above forward, which also opens the
        // negative discriminant path.
        write_reg(REG_GAIN_COEFF, 32'h7FFFFFFF);
        write_reg(REG_SPEED_COEFF, 32'd3);
        write_reg(REG_FORWARD_LIMIT, 32'd0);
        write_reg(REG_REVERSE_LIMIT, 32'd65536);
        write_reg(REG_MIDDLE_SIGNAL, 32'd0);
        send_item(32'd5, 32'd100);
        send_item(32'h80000000, 32'h80000000);
        write_reg(REG_FORWARD_LIMIT, 32'd1000);
        send_item(32'd500, 32'd7);
        send_item(32'd1, 32'hFFFFFFF0);
        s_tvalid <= 1'b0;
        drain();

        // Random phases, each with new register values.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 16 : 0;
            write_reg(REG_GAIN_COEFF, $urandom_range(1) ? $urandom : $urandom_range(1 << 18));
            write_reg(REG_SPEED_COEFF, $urandom_range(1) ? $urandom : $urandom_range(1 << 17));
            write_reg(REG_FORWARD_LIMIT, $urandom);
            write_reg(REG_REVERSE_LIMIT, $urandom_range(3) == 0 ? $urandom : {1'b1, 31'($urandom)});
            write_reg(REG_MIDDLE_SIGNAL, $urandom);
            if (ph == 2)
            begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                begin
                    hold_off = 1'b1;
                    repeat (400) @(posedge clk);
                    hold_off = 1'b0;
                end
                join_none
            end
            for (int n = 0; n < 330; n++)
                send_item(rand_word(), rand_word());
            s_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### thrust_curve_inverse_unit.f
+incdir+rtl/core
rtl/core/tci_pkg.sv
rtl/core/tci_sqrt_cell.sv
rtl/core/tci_div_cell.sv
rtl/core/thrust_curve_inverse_unit.sv
rtl/core/tci_checker.sv
bench/thrust_curve_inverse_unit_tb.sv
